// ===== rtl/q4dq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q4dq_pkg
// Shared widths, pipeline control type and saturating add for the 4-bit
// block-quantized dequantize and dot product core.
// ----------------------------------------------------------------------------
package q4dq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int ACC_WIDTH  = 48;
   localparam int ROW_W      = 16;
   localparam int NIB_W      = 4;
   localparam int PW_W       = 2 * NIB_W;
   localparam int WA_W       = NIB_W + DATA_WIDTH;
   localparam int PROD_W     = WA_W + DATA_WIDTH;
   localparam int EXT_W      = (PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH;

   localparam int REQ_FIELDS_W = PW_W + 3 * DATA_WIDTH;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ACC_WIDTH + ROW_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic valid;
      logic odd;
      logic last;
   } stage_ctrl_type;

   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] acc,
      input logic signed [ACC_WIDTH-1:0] p
   );
      logic signed [ACC_WIDTH:0] s;
      s = {acc[ACC_WIDTH-1], acc} + {p[ACC_WIDTH-1], p};
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/q4_dequant_dot_product_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q4_dequant_dot_product_core
// Row dot product of 4-bit block-quantized weights with Q4.12 activations.
//
// req channel: one beat per weight block. tlast marks the last block of a
// row; tuser set means the odd column (high nibble) is part of the row.
// rsp channel: one beat per row, carrying the saturated Q24.24 row sum and
// the row index (wraps at 65536). Mid-row blocks produce no beat.
// A row-ending block passes the stage 1 and stage 2 registers; when it
// is merged, the rsp_valid register is set and drives rsp_tvalid.
// Throughput: one block per cycle unless a row end waits at merge.
// Two lanes multiply the even and odd columns in two stages each; the
// merge does both saturating adds combinationally, which sets the loop.
// When rsp stalls with a row sum held, blocks keep flowing until a second
// row-ending block reaches the merge stage; it then waits and the
// pipeline backs up to req_tready.
// Reset clears the accumulator, the row counter and all stage valids.
// ----------------------------------------------------------------------------
module q4_dequant_dot_product_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // packed_weights, block_scale, act_even, act_odd
   input  wire logic [q4dq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // odd_present
   input  wire logic                                 req_tuser,
   // row_end
   input  wire logic                                 req_tlast,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // row_sum, row_number
   output      logic [q4dq_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int NW  = q4dq_pkg::NIB_W;
   localparam int DW  = q4dq_pkg::DATA_WIDTH;
   localparam int PWW = q4dq_pkg::PW_W;

   logic [PWW-1:0]                          packed_weights;
   logic signed [DW-1:0]                    block_scale;
   logic signed [DW-1:0]                    act_even;
   logic signed [DW-1:0]                    act_odd;
   q4dq_pkg::stage_ctrl_type                s1_ctrl_in;
   q4dq_pkg::stage_ctrl_type                s1_ctrl_ff;
   q4dq_pkg::stage_ctrl_type                s2_ctrl_in;
   q4dq_pkg::stage_ctrl_type                s2_ctrl_ff;
   logic                                    s1_ready;
   logic                                    s2_ready;
   logic                                    merge_ready;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]   prod_even;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]   prod_odd;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]   row_sum;
   logic [q4dq_pkg::ROW_W-1:0]              row_number;

   assign packed_weights = req_tdata[PWW-1:0];
   assign block_scale    = req_tdata[PWW+DW-1:PWW];
   assign act_even       = req_tdata[PWW+2*DW-1:PWW+DW];
   assign act_odd        = req_tdata[PWW+3*DW-1:PWW+2*DW];

   assign s2_ready   = !s2_ctrl_ff.valid || merge_ready;
   assign s1_ready   = !s1_ctrl_ff.valid || s2_ready;
   assign req_tready = s1_ready;

   always_comb begin
      s1_ctrl_in = s1_ctrl_ff;
      s2_ctrl_in = s2_ctrl_ff;
      if (s1_ready) begin
         s1_ctrl_in.valid = req_tvalid;
         s1_ctrl_in.odd   = req_tuser;
         s1_ctrl_in.last  = req_tlast;
      end
      if (s2_ready) begin
         s2_ctrl_in = s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s2_ctrl_in;
      end
   end

   q4dq_lane u_lane_even (
      .clock   (clock),
      .en1     (s1_ready),
      .en2     (s2_ready),
      .nibble  (packed_weights[NW-1:0]),
      .act     (act_even),
      .scale   (block_scale),
      .product (prod_even)
   );

   q4dq_lane u_lane_odd (
      .clock   (clock),
      .en1     (s1_ready),
      .en2     (s2_ready),
      .nibble  (packed_weights[2*NW-1:NW]),
      .act     (act_odd),
      .scale   (block_scale),
      .product (prod_odd)
   );

   q4dq_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (s2_ctrl_ff),
      .prod_even   (prod_even),
      .prod_odd    (prod_odd),
      .rsp_tready  (rsp_tready),
      .merge_ready (merge_ready),
      .rsp_valid   (rsp_tvalid),
      .row_sum     (row_sum),
      .row_number  (row_number)
   );

   assign rsp_tdata = q4dq_pkg::RSP_TDATA_W'({row_number, row_sum});

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s2_ctrl_ff.valid && s2_ctrl_ff.last && rsp_tvalid && !rsp_tready) |-> !merge_ready)
      else $error("row end merged while a row sum is held");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_ctrl_ff.valid)
      else $error("accepted beat lost at stage 1");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_ctrl_ff.valid && !s2_ready) |=> (s1_ctrl_ff.valid && $stable(s1_ctrl_ff)))
      else $error("stage 1 changed while stalled");

   a_row_end_emits: assert property (@(posedge clock) disable iff (reset)
      (s2_ctrl_ff.valid && s2_ctrl_ff.last && merge_ready) |=> rsp_tvalid)
      else $error("row end merged without a result beat");

endmodule
`default_nettype wire

// ===== rtl/q4dq_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q4dq_lane
// One weight lane: decodes a nibble as n - 8, multiplies by the activation,
// then by the block scale, and clamps the product to the accumulator range.
// ----------------------------------------------------------------------------
module q4dq_lane (
   input  wire logic                                     clock,
   input  wire logic                                     en1,
   input  wire logic                                     en2,
   input  wire logic [q4dq_pkg::NIB_W-1:0]               nibble,
   input  wire logic signed [q4dq_pkg::DATA_WIDTH-1:0]   act,
   input  wire logic signed [q4dq_pkg::DATA_WIDTH-1:0]   scale,
   output      logic signed [q4dq_pkg::ACC_WIDTH-1:0]    product
);

   logic signed [q4dq_pkg::NIB_W-1:0]      weight;
   logic signed [q4dq_pkg::WA_W-1:0]       wa_in;
   logic signed [q4dq_pkg::WA_W-1:0]       wa_ff;
   logic signed [q4dq_pkg::DATA_WIDTH-1:0] scale_ff;
   logic signed [q4dq_pkg::PROD_W-1:0]     prod_full;
   logic signed [q4dq_pkg::EXT_W-1:0]      prod_ext;
   logic signed [q4dq_pkg::EXT_W-1:0]      max_ext;
   logic signed [q4dq_pkg::EXT_W-1:0]      min_ext;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]  product_in;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]  product_ff;

   // n - 8 on four bits is n with its top bit flipped
   assign weight = {~nibble[q4dq_pkg::NIB_W-1], nibble[q4dq_pkg::NIB_W-2:0]};
   assign wa_in  = weight * act;

   always_ff @(posedge clock) begin
      if (en1) begin
         wa_ff    <= wa_in;
         scale_ff <= scale;
      end
   end

   assign prod_full = wa_ff * scale_ff;
   assign prod_ext  = q4dq_pkg::EXT_W'(prod_full);
   assign max_ext   = q4dq_pkg::EXT_W'(q4dq_pkg::ACC_MAX);
   assign min_ext   = q4dq_pkg::EXT_W'(q4dq_pkg::ACC_MIN);

   always_comb begin
      if (prod_ext > max_ext) begin
         product_in = q4dq_pkg::ACC_MAX;
      end else if (prod_ext < min_ext) begin
         product_in = q4dq_pkg::ACC_MIN;
      end else begin
         product_in = prod_ext[q4dq_pkg::ACC_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule
`default_nettype wire

// ===== rtl/q4dq_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// q4dq_merge
// Adds the even and odd lane products into the saturating row accumulator,
// counts rows and holds the finished row sum in the output register.
// ----------------------------------------------------------------------------
module q4dq_merge (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire q4dq_pkg::stage_ctrl_type                ctrl,
   input  wire logic signed [q4dq_pkg::ACC_WIDTH-1:0]   prod_even,
   input  wire logic signed [q4dq_pkg::ACC_WIDTH-1:0]   prod_odd,
   input  wire logic                                    rsp_tready,
   output      logic                                    merge_ready,
   output      logic                                    rsp_valid,
   output      logic signed [q4dq_pkg::ACC_WIDTH-1:0]   row_sum,
   output      logic [q4dq_pkg::ROW_W-1:0]              row_number
);

   logic                                   out_free;
   logic                                   fire;
   logic                                   row_done;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]  acc_mid;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]  acc_new;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]  acc_in;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]  acc_ff;
   logic [q4dq_pkg::ROW_W-1:0]             row_cnt_in;
   logic [q4dq_pkg::ROW_W-1:0]             row_cnt_ff;
   logic                                   rsp_valid_in;
   logic                                   rsp_valid_ff;
   logic signed [q4dq_pkg::ACC_WIDTH-1:0]  sum_ff;
   logic [q4dq_pkg::ROW_W-1:0]             number_ff;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign merge_ready = !ctrl.last || out_free;
   assign fire        = ctrl.valid && merge_ready;
   assign row_done    = fire && ctrl.last;

   // even term first, then odd: each add saturates on its own
   assign acc_mid = q4dq_pkg::sat_add(acc_ff, prod_even);
   assign acc_new = ctrl.odd ? q4dq_pkg::sat_add(acc_mid, prod_odd) : acc_mid;

   always_comb begin
      acc_in       = acc_ff;
      row_cnt_in   = row_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fire) begin
         acc_in = acc_new;
      end
      if (row_done) begin
         acc_in       = '0;
         row_cnt_in   = row_cnt_ff + 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (row_done) begin
         sum_ff    <= acc_new;
         number_ff <= row_cnt_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign row_sum    = sum_ff;
   assign row_number = number_ff;

endmodule
`default_nettype wire
